// File: rtl/h2kr_pkg.sv
// Shared types, constants and mod-26 helper functions for the Hill key recovery block.
`default_nettype none
package h2kr_pkg;

  localparam int unsigned Letters = 26;
  localparam int unsigned LetterW = 5;
  localparam int unsigned ProdW   = 2 * LetterW;
  localparam int unsigned SumW    = ProdW + 1;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [ProdW-1:0]   prod_t;
  typedef logic [SumW-1:0]    sum_t;

  typedef struct packed {
    letter_t m00;
    letter_t m01;
    letter_t m10;
    letter_t m11;
  } mat_t;

  // Folds a raw 5-bit field into 0..25.
  function automatic letter_t fold_letter(input letter_t v);
    letter_t r;
    r = (v >= letter_t'(Letters)) ? letter_t'(v - letter_t'(Letters)) : v;
    return r;
  endfunction

  // Reduces a value below 2048 mod 26. The reciprocal 39/1024 underestimates
  // the quotient by less than one, so a single compare and subtract finishes it.
  function automatic letter_t mod26(input sum_t v);
    logic [16:0] t;
    logic [6:0]  q;
    sum_t        r;
    t = 17'(v) * 17'(39);
    q = t[16:10];
    r = v - sum_t'(sum_t'(q) * sum_t'(Letters));
    return (r >= sum_t'(Letters)) ? letter_t'(r - sum_t'(Letters)) : letter_t'(r);
  endfunction

  // Additive inverse of a letter in 0..25.
  function automatic letter_t neg26(input letter_t v);
    return (v == '0) ? '0 : letter_t'(letter_t'(Letters) - v);
  endfunction

  // Multiplicative inverse mod 26; zero when none exists.
  function automatic letter_t inv26(input letter_t v);
    letter_t r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/h2kr_det.sv
// Determinant, its inverse mod 26 and the adjugate of the plaintext matrix, two stages.
`default_nettype none
module h2kr_det (
  input  wire              clk_i,
  input  wire              en1_i,
  input  wire              en2_i,
  input  h2kr_pkg::mat_t   plain_i,
  input  h2kr_pkg::mat_t   cipher_i,
  output h2kr_pkg::mat_t   adj_o,
  output h2kr_pkg::letter_t dinv_o,
  output h2kr_pkg::mat_t   cipher_o
);

  h2kr_pkg::mat_t   p_d, p_q, c1_d, c1_q, adj_d, adj_q, c2_q;
  h2kr_pkg::prod_t  pa_d, pa_q, pb_d, pb_q;
  h2kr_pkg::letter_t det_a, det_b, det_s, dinv_d, dinv_q;
  logic [h2kr_pkg::LetterW:0] det_sum;

  always_comb begin
    p_d.m00  = h2kr_pkg::fold_letter(plain_i.m00);
    p_d.m01  = h2kr_pkg::fold_letter(plain_i.m01);
    p_d.m10  = h2kr_pkg::fold_letter(plain_i.m10);
    p_d.m11  = h2kr_pkg::fold_letter(plain_i.m11);
    c1_d.m00 = h2kr_pkg::fold_letter(cipher_i.m00);
    c1_d.m01 = h2kr_pkg::fold_letter(cipher_i.m01);
    c1_d.m10 = h2kr_pkg::fold_letter(cipher_i.m10);
    c1_d.m11 = h2kr_pkg::fold_letter(cipher_i.m11);
    pa_d = h2kr_pkg::prod_t'(p_d.m00) * h2kr_pkg::prod_t'(p_d.m11);
    pb_d = h2kr_pkg::prod_t'(p_d.m01) * h2kr_pkg::prod_t'(p_d.m10);
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      p_q  <= p_d;
      c1_q <= c1_d;
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  always_comb begin
    det_a   = h2kr_pkg::mod26(h2kr_pkg::sum_t'(pa_q));
    det_b   = h2kr_pkg::mod26(h2kr_pkg::sum_t'(pb_q));
    // Adding 26 first keeps the difference non-negative.
    det_sum = (h2kr_pkg::LetterW+1)'(det_a) + (h2kr_pkg::LetterW+1)'(h2kr_pkg::Letters)
            - (h2kr_pkg::LetterW+1)'(det_b);
    det_s   = (det_sum >= (h2kr_pkg::LetterW+1)'(h2kr_pkg::Letters))
            ? h2kr_pkg::letter_t'(det_sum - (h2kr_pkg::LetterW+1)'(h2kr_pkg::Letters))
            : h2kr_pkg::letter_t'(det_sum);
    dinv_d  = h2kr_pkg::inv26(det_s);
    adj_d.m00 = p_q.m11;
    adj_d.m01 = h2kr_pkg::neg26(p_q.m01);
    adj_d.m10 = h2kr_pkg::neg26(p_q.m10);
    adj_d.m11 = p_q.m00;
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      adj_q  <= adj_d;
      dinv_q <= dinv_d;
      c2_q   <= c1_q;
    end
  end

  assign adj_o    = adj_q;
  assign dinv_o   = dinv_q;
  assign cipher_o = c2_q;

endmodule
`default_nettype wire

// File: rtl/h2kr_lane.sv
// One key lane: dot product of an inverse row with a ciphertext column.
`default_nettype none
module h2kr_lane (
  input  wire               clk_i,
  input  wire               en_i,
  input  h2kr_pkg::letter_t row0_i,
  input  h2kr_pkg::letter_t row1_i,
  input  h2kr_pkg::letter_t col0_i,
  input  h2kr_pkg::letter_t col1_i,
  output h2kr_pkg::sum_t    sum_o
);

  h2kr_pkg::prod_t prod0, prod1;
  h2kr_pkg::sum_t  sum_d, sum_q;

  always_comb begin
    prod0 = h2kr_pkg::prod_t'(row0_i) * h2kr_pkg::prod_t'(col0_i);
    prod1 = h2kr_pkg::prod_t'(row1_i) * h2kr_pkg::prod_t'(col1_i);
    sum_d = h2kr_pkg::sum_t'(prod0) + h2kr_pkg::sum_t'(prod1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

// File: rtl/h2kr_merge.sv
// Merge stage: reduces the four lane sums mod 26 into the output register.
`default_nettype none
module h2kr_merge (
  input  wire               clk_i,
  input  wire               en_i,
  input  h2kr_pkg::sum_t    sum00_i,
  input  h2kr_pkg::sum_t    sum01_i,
  input  h2kr_pkg::sum_t    sum10_i,
  input  h2kr_pkg::sum_t    sum11_i,
  input  wire               inv_ok_i,
  output h2kr_pkg::mat_t    key_o,
  output logic              inv_ok_o
);

  h2kr_pkg::mat_t key_d, key_q;
  logic           inv_ok_q;

  always_comb begin
    key_d.m00 = h2kr_pkg::mod26(sum00_i);
    key_d.m01 = h2kr_pkg::mod26(sum01_i);
    key_d.m10 = h2kr_pkg::mod26(sum10_i);
    key_d.m11 = h2kr_pkg::mod26(sum11_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q    <= key_d;
      inv_ok_q <= inv_ok_i;
    end
  end

  assign key_o    = key_q;
  assign inv_ok_o = inv_ok_q;

endmodule
`default_nettype wire

// File: rtl/hill2x2_key_recovery_mod26.sv
// Throughput: one word per cycle while the output is not stalled; each of the five
// stages advances whenever it is empty or the stage after it advances, so bubbles
// close up under output stalls. Four parallel lanes compute the key entries.
// Reset clears only the stage valid bits; payload registers are not reset.
`default_nettype none
module hill2x2_key_recovery_mod26 (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [4:0] plain_r0c0_i,
  input  wire  [4:0] plain_r0c1_i,
  input  wire  [4:0] plain_r1c0_i,
  input  wire  [4:0] plain_r1c1_i,
  input  wire  [4:0] cipher_r0c0_i,
  input  wire  [4:0] cipher_r0c1_i,
  input  wire  [4:0] cipher_r1c0_i,
  input  wire  [4:0] cipher_r1c1_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [4:0] key_r0c0_o,
  output logic [4:0] key_r0c1_o,
  output logic [4:0] key_r1c0_o,
  output logic [4:0] key_r1c1_o,
  output logic       invertible_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  h2kr_pkg::mat_t    plain, cipher, adj, c2, inv_d, inv_q, c3_q, key;
  h2kr_pkg::letter_t dinv;
  h2kr_pkg::sum_t    s00, s01, s10, s11;
  logic              ok3_q, ok4_q, ok_out;

  // Each stage moves forward when it is empty or its successor moves.
  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  assign plain  = '{m00: plain_r0c0_i, m01: plain_r0c1_i,
                    m10: plain_r1c0_i, m11: plain_r1c1_i};
  assign cipher = '{m00: cipher_r0c0_i, m01: cipher_r0c1_i,
                    m10: cipher_r1c0_i, m11: cipher_r1c1_i};

  h2kr_det u_det (
    .clk_i    (clk_i),
    .en1_i    (en1),
    .en2_i    (en2),
    .plain_i  (plain),
    .cipher_i (cipher),
    .adj_o    (adj),
    .dinv_o   (dinv),
    .cipher_o (c2)
  );

  // Scale the adjugate by the determinant inverse; a zero inverse zeroes the key.
  always_comb begin
    inv_d.m00 = h2kr_pkg::mod26(h2kr_pkg::sum_t'(h2kr_pkg::prod_t'(adj.m00) *
                                                 h2kr_pkg::prod_t'(dinv)));
    inv_d.m01 = h2kr_pkg::mod26(h2kr_pkg::sum_t'(h2kr_pkg::prod_t'(adj.m01) *
                                                 h2kr_pkg::prod_t'(dinv)));
    inv_d.m10 = h2kr_pkg::mod26(h2kr_pkg::sum_t'(h2kr_pkg::prod_t'(adj.m10) *
                                                 h2kr_pkg::prod_t'(dinv)));
    inv_d.m11 = h2kr_pkg::mod26(h2kr_pkg::sum_t'(h2kr_pkg::prod_t'(adj.m11) *
                                                 h2kr_pkg::prod_t'(dinv)));
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      inv_q <= inv_d;
      c3_q  <= c2;
      ok3_q <= (dinv != '0);
    end
    if (en4) begin
      ok4_q <= ok3_q;
    end
  end

  h2kr_lane u_lane00 (
    .clk_i (clk_i), .en_i (en4),
    .row0_i (inv_q.m00), .row1_i (inv_q.m01),
    .col0_i (c3_q.m00),  .col1_i (c3_q.m10),
    .sum_o (s00)
  );

  h2kr_lane u_lane01 (
    .clk_i (clk_i), .en_i (en4),
    .row0_i (inv_q.m00), .row1_i (inv_q.m01),
    .col0_i (c3_q.m01),  .col1_i (c3_q.m11),
    .sum_o (s01)
  );

  h2kr_lane u_lane10 (
    .clk_i (clk_i), .en_i (en4),
    .row0_i (inv_q.m10), .row1_i (inv_q.m11),
    .col0_i (c3_q.m00),  .col1_i (c3_q.m10),
    .sum_o (s10)
  );

  h2kr_lane u_lane11 (
    .clk_i (clk_i), .en_i (en4),
    .row0_i (inv_q.m10), .row1_i (inv_q.m11),
    .col0_i (c3_q.m01),  .col1_i (c3_q.m11),
    .sum_o (s11)
  );

  h2kr_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en5),
    .sum00_i  (s00),
    .sum01_i  (s01),
    .sum10_i  (s10),
    .sum11_i  (s11),
    .inv_ok_i (ok4_q),
    .key_o    (key),
    .inv_ok_o (ok_out)
  );

  assign out_valid_o  = v5_q;
  assign key_r0c0_o   = key.m00;
  assign key_r0c1_o   = key.m01;
  assign key_r1c0_o   = key.m10;
  assign key_r1c1_o   = key.m11;
  assign invertible_o = ok_out;

  // The pipeline only refuses a word when the output holds a word that is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // An accepted word always occupies the first stage on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted word lost at first stage");

  // A singular plaintext yields an all-zero key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !invertible_o) |->
      (key.m00 == '0 && key.m01 == '0 && key.m10 == '0 && key.m11 == '0))
    else $error("nonzero key for singular plaintext");

  // Every delivered key entry is a proper residue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (key.m00 < 5'd26 && key.m01 < 5'd26 &&
                     key.m10 < 5'd26 && key.m11 < 5'd26))
    else $error("key entry out of range");

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the 2x2 Hill key recovery block (mod 26).
module testbench;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 120;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned RandomPerPhase = 500;

  typedef struct packed {
    h2kr_pkg::mat_t key;
    logic           invertible;
  } key_word_t;

  class key_scoreboard;
    key_word_t   expected_keys[$];
    int unsigned faults;

    function new();
      faults = 0;
    endfunction

    // Solves K = P^-1 * C with every entry kept in 0..25.
    function key_word_t recover_key(h2kr_pkg::mat_t p, h2kr_pkg::mat_t c);
      int        a, b, g, d, det, dinv, i;
      int        i00, i01, i10, i11;
      int        c00, c01, c10, c11;
      key_word_t kw;
      a   = int'(p.m00) % 26;
      b   = int'(p.m01) % 26;
      g   = int'(p.m10) % 26;
      d   = int'(p.m11) % 26;
      c00 = int'(c.m00) % 26;
      c01 = int'(c.m01) % 26;
      c10 = int'(c.m10) % 26;
      c11 = int'(c.m11) % 26;
      det = ((a * d - b * g) % 26 + 26) % 26;
      dinv = 0;
      for (i = 1; i < 26; i++) begin
        if (dinv == 0 && (det * i) % 26 == 1) begin
          dinv = i;
        end
      end
      i00 = (d * dinv) % 26;
      i01 = (((26 - b) % 26) * dinv) % 26;
      i10 = (((26 - g) % 26) * dinv) % 26;
      i11 = (a * dinv) % 26;
      kw.key.m00  = h2kr_pkg::letter_t'((i00 * c00 + i01 * c10) % 26);
      kw.key.m01  = h2kr_pkg::letter_t'((i00 * c01 + i01 * c11) % 26);
      kw.key.m10  = h2kr_pkg::letter_t'((i10 * c00 + i11 * c10) % 26);
      kw.key.m11  = h2kr_pkg::letter_t'((i10 * c01 + i11 * c11) % 26);
      kw.invertible = (dinv != 0);
      return kw;
    endfunction

    function void note_pair(h2kr_pkg::mat_t p, h2kr_pkg::mat_t c);
      expected_keys.push_back(recover_key(p, c));
    endfunction

    function void check_key(key_word_t got);
      key_word_t want;
      if (expected_keys.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("ERROR: key word with none expected: %0d %0d %0d %0d inv=%0d",
                   got.key.m00, got.key.m01, got.key.m10, got.key.m11, got.invertible);
        end
        return;
      end
      want = expected_keys.pop_front();
      if (got.key.m00 !== want.key.m00 || got.key.m01 !== want.key.m01 ||
          got.key.m10 !== want.key.m10 || got.key.m11 !== want.key.m11 ||
          got.invertible !== want.invertible) begin
        faults++;
        if (faults <= 10) begin
          $display({"ERROR: key mismatch, expected %0d %0d %0d %0d inv=%0d,",
                    " got %0d %0d %0d %0d inv=%0d"},
                   want.key.m00, want.key.m01, want.key.m10, want.key.m11, want.invertible,
                   got.key.m00, got.key.m01, got.key.m10, got.key.m11, got.invertible);
        end
      end
    endfunction

    function int unsigned pending_count();
      return expected_keys.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  h2kr_pkg::letter_t plain_r0c0_i, plain_r0c1_i, plain_r1c0_i, plain_r1c1_i;
  h2kr_pkg::letter_t cipher_r0c0_i, cipher_r0c1_i, cipher_r1c0_i, cipher_r1c1_i;
  logic              out_valid_o;
  logic              out_ready_i;
  h2kr_pkg::letter_t key_r0c0_o, key_r0c1_o, key_r1c0_o, key_r1c1_o;
  logic              invertible_o;

  key_scoreboard sb;
  int unsigned   tx_idle_pct;
  int unsigned   rx_idle_pct;
  bit            hold_req;
  int unsigned   quiet_cycles;

  hill2x2_key_recovery_mod26 DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .plain_r0c0_i (plain_r0c0_i),
    .plain_r0c1_i (plain_r0c1_i),
    .plain_r1c0_i (plain_r1c0_i),
    .plain_r1c1_i (plain_r1c1_i),
    .cipher_r0c0_i(cipher_r0c0_i),
    .cipher_r0c1_i(cipher_r0c1_i),
    .cipher_r1c0_i(cipher_r1c0_i),
    .cipher_r1c1_i(cipher_r1c1_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_r0c0_o   (key_r0c0_o),
    .key_r0c1_o   (key_r0c1_o),
    .key_r1c0_o   (key_r1c0_o),
    .key_r1c1_o   (key_r1c1_o),
    .invertible_o (invertible_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic h2kr_pkg::mat_t mat(int unsigned a, int unsigned b, int unsigned c,
                                         int unsigned d);
    h2kr_pkg::mat_t m;
    m.m00 = h2kr_pkg::letter_t'(a);
    m.m01 = h2kr_pkg::letter_t'(b);
    m.m10 = h2kr_pkg::letter_t'(c);
    m.m11 = h2kr_pkg::letter_t'(d);
    return m;
  endfunction

  // Mostly proper letters, with some raw values up to 31 mixed in.
  function automatic h2kr_pkg::letter_t rand_letter();
    return ($urandom_range(99) < 85) ? h2kr_pkg::letter_t'($urandom_range(25))
                                     : h2kr_pkg::letter_t'($urandom_range(31));
  endfunction

  function automatic h2kr_pkg::mat_t rand_mat();
    return mat(rand_letter(), rand_letter(), rand_letter(), rand_letter());
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic send_word(h2kr_pkg::mat_t p, h2kr_pkg::mat_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    plain_r0c0_i  <= p.m00;
    plain_r0c1_i  <= p.m01;
    plain_r1c0_i  <= p.m10;
    plain_r1c1_i  <= p.m11;
    cipher_r0c0_i <= c.m00;
    cipher_r0c1_i <= c.m01;
    cipher_r1c0_i <= c.m10;
    cipher_r1c1_i <= c.m11;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_word(rand_mat(), rand_mat());
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_pair(mat(plain_r0c0_i, plain_r0c1_i, plain_r1c0_i, plain_r1c1_i),
                     mat(cipher_r0c0_i, cipher_r0c1_i, cipher_r1c0_i, cipher_r1c1_i));
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_key({mat(key_r0c0_o, key_r0c1_o, key_r1c0_o, key_r1c1_o), invertible_o});
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int unsigned u;
    sb           = new();
    quiet_cycles = 0;
    hold_req     = 1'b0;
    tx_idle_pct  = 35;
    rx_idle_pct  = 73;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    plain_r0c0_i  <= '0;
    plain_r0c1_i  <= '0;
    plain_r1c0_i  <= '0;
    plain_r1c1_i  <= '0;
    cipher_r0c0_i <= '0;
    cipher_r0c1_i <= '0;
    cipher_r1c0_i <= '0;
    cipher_r1c1_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: zero and full-scale fields, raw values above 25,
    // singular determinants (zero, even, thirteen) and every unit determinant.
    send_word(mat(0, 0, 0, 0), mat(0, 0, 0, 0));
    send_word(mat(1, 0, 0, 1), mat(25, 25, 25, 25));
    send_word(mat(25, 25, 25, 25), mat(25, 25, 25, 25));
    send_word(mat(25, 0, 0, 25), mat(0, 25, 25, 0));
    send_word(mat(31, 31, 31, 31), mat(31, 31, 31, 31));
    send_word(mat(26, 27, 28, 29), mat(30, 31, 26, 27));
    send_word(mat(13, 0, 0, 1), mat(1, 2, 3, 4));
    send_word(mat(2, 0, 0, 1), mat(5, 6, 7, 8));
    send_word(mat(0, 1, 1, 0), mat(31, 0, 0, 31));
    send_word(mat(3, 3, 2, 5), mat(7, 8, 11, 11));
    for (u = 1; u < 26; u += 2) begin
      if (u != 13) begin
        send_word(mat(u, 0, 0, 1), rand_mat());
      end
    end

    send_random(RandomPerPhase);

    tx_idle_pct = 73;
    rx_idle_pct = 35;
    send_random(RandomPerPhase);

    // No idling; one long receiver hold-off backs the pipeline up into the input.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    send_random(RandomPerPhase);
    in_valid_i <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.faults == 0 && sb.pending_count() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
